@@ rtl/goal_approach_velocity_shaper_macros.svh @@
// ----------------------------------------------------------------------------
// Goal approach velocity shaper - assertion macros
// Concurrent assertion shorthands clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef GOAL_APPROACH_VELOCITY_SHAPER_MACROS_SVH
`define GOAL_APPROACH_VELOCITY_SHAPER_MACROS_SVH

// same-cycle implication
`define GAVS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GAVS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/gavs_pkg.sv @@
// ----------------------------------------------------------------------------
// gavs_pkg
// Types, constants and helper functions of the goal approach velocity shaper.
// ----------------------------------------------------------------------------
package gavs_pkg;

  localparam int FRAC_BITS        = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int GUARD            = 8;

  localparam int VW  = 48;
  localparam int AW  = 36;
  localparam int DW  = 34;
  localparam int MAW = 35;
  localparam int MBW = 32;
  localparam int PW  = MAW + MBW;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [AW-1:0] ANG_PI      = 36'sd3373259426;
  localparam logic signed [AW-1:0] ANG_HALF_PI = 36'sd1686629713;
  localparam logic signed [AW-1:0] ANG_TWO_PI  = 36'sd6746518852;
  localparam logic [29:0]          INV_GAIN    = 30'd652032875;
  localparam logic signed [33:0]   QUAT_ONE    = 34'sd268435456;

  localparam logic [DW-1:0] EPS_DIST = DW'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [31:0]   TENTH    = 32'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

  localparam logic OP_PLAN = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_APPROACH_DIST  = 3'd0,
    REG_APPROACH_SPEED = 3'd1,
    REG_ENTER_DIST     = 3'd2,
    REG_EXIT_DIST      = 3'd3,
    REG_DIRECT_GAIN    = 3'd4,
    REG_MAX_YAW_RATE   = 3'd5,
    REG_GOAL_X         = 3'd6,
    REG_GOAL_Y         = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    ZONE_PASS     = 2'd0,
    ZONE_NO_GOAL  = 2'd1,
    ZONE_APPROACH = 2'd2,
    ZONE_DIRECT   = 2'd3
  } zone_t;

  typedef enum logic [1:0] {
    JOB_DIST,
    JOB_YAW,
    JOB_SPEED,
    JOB_ROT
  } job_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_VLOAD,
    S_ITER,
    S_POST,
    S_MAG1,
    S_MAG2,
    S_DECIDE,
    S_QUAT,
    S_TGT0,
    S_TGT1,
    S_ANG,
    S_WRAP,
    S_FOLD,
    S_RLOAD,
    S_SPDCHK,
    S_PROD,
    S_DVLD,
    S_DIV,
    S_DSTORE,
    S_CLAMP,
    S_OUT
  } state_t;

  function automatic logic [29:0] atan_entry(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837830;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      5'd24: v = 30'd64;
      5'd25: v = 30'd32;
      5'd26: v = 30'd16;
      5'd27: v = 30'd8;
      5'd28: v = 30'd4;
      5'd29: v = 30'd2;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [VW-1:0] v);
    logic signed [31:0] r;
    if (v > VW'(64'sd2147483647)) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -VW'(64'sd2147483648)) begin
      r = 32'sh80000000;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

endpackage

@@ rtl/gavs_if.sv @@
// ----------------------------------------------------------------------------
// gavs_if
// Valid/ready channels of the goal approach velocity shaper.
// ----------------------------------------------------------------------------
interface gavs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface gavs_step_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [31:0] cmd_vx;
  logic signed [31:0] cmd_vy;
  logic signed [31:0] cmd_wz;
  modport source (output valid, op, pose_x, pose_y, quat_w, quat_x, quat_y, quat_z,
                  cmd_vx, cmd_vy, cmd_wz, input ready);
  modport sink (input valid, op, pose_x, pose_y, quat_w, quat_x, quat_y, quat_z,
                cmd_vx, cmd_vy, cmd_wz, output ready);
endinterface

interface gavs_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_vx;
  logic signed [31:0] out_vy;
  logic signed [31:0] out_wz;
  logic               direct_active;
  logic [1:0]         zone;
  modport source (output valid, out_vx, out_vy, out_wz, direct_active, zone, input ready);
  modport sink (input valid, out_vx, out_vy, out_wz, direct_active, zone, output ready);
endinterface

@@ rtl/goal_approach_velocity_shaper.sv @@
// ----------------------------------------------------------------------------
// goal_approach_velocity_shaper
// Shapes a velocity command by distance to goal with a hysteretic direct drive.
// ----------------------------------------------------------------------------
//  channel  dir  beat
//  cfg      in   index, data (register write)
//  step     in   op, pose, quaternion, command
//  result   out  shaped command, direct_active, zone
//
//  One item at a time; one CORDIC unit, one multiplier, one radix-2 divider.
//  Plan beat: no result. No goal: the result follows in the next cycle.
//  Pass-through, direct and approach steps all run CORDIC vectoring; an approach
//  step above the approach speed adds three divisions, one per command component.
//  Reset is synchronous; a stalled result holds the block until taken.
// ----------------------------------------------------------------------------
module goal_approach_velocity_shaper #(
  parameter int CORDIC_STEPS = gavs_pkg::CORDIC_STEPS_DEF
) (
  input logic           clk,
  input logic           rst,
  gavs_cfg_if.sink      cfg,
  gavs_step_if.sink     step,
  gavs_result_if.source result
);
  import gavs_pkg::*;

  localparam int            IW        = $clog2(CORDIC_STEPS);
  localparam logic [IW-1:0] ITER_LAST = IW'(CORDIC_STEPS - 1);

  state_t state, state_next;
  job_t   job;
  logic [IW-1:0] it;
  logic [2:0]    k;
  logic [4:0]    dcnt;
  logic          goal_known, direct_mode;

  logic [30:0]        r_ad, r_av, r_en, r_ex, r_m;
  logic [15:0]        r_gain;
  logic signed [31:0] r_gx, r_gy;

  logic signed [31:0] cvx, cvy, cwz;
  logic signed [15:0] qw, qx, qy, qz;
  logic signed [32:0] dx, dy, qs, qc;
  logic signed [VW-1:0] cx, cy;
  logic signed [AW-1:0] cz;
  logic                 vzero;
  logic signed [PW-1:0] pr;
  logic [53:0]          acc;
  logic [DW-1:0]        goal_dist, spd;
  logic signed [AW-1:0] phi, yaw_ang, ang;
  logic                 rneg;
  logic [30:0]          target;
  logic signed [31:0]   ovx, ovy, owz;
  logic [1:0]           zone;
  logic [33:0]          rem;
  logic [31:0]          nlo, quo;
  logic                 dneg;

  logic signed [MAW-1:0] ma;
  logic signed [MBW-1:0] mb;
  logic signed [33:0]    cyq, syq;
  logic signed [VW-1:0]  sx, sy, xs, ys, cx_n, cy_n, rlen_s;
  logic signed [AW-1:0]  cz_n, at;
  logic                  dir;
  logic [VW-1:0]         ux;
  logic [71:0]           mag_full;
  logic [DW-1:0]         mag;
  logic [30:0]           enter;
  logic [31:0]           exitd;
  logic                  dm_n;
  logic [41:0]           tgt_raw;
  logic [PW-1:0]         pabs;
  logic [34:0]           rs;
  logic                  rge;
  logic signed [31:0]    cmd_k, quo_s;

  // vector source
  always_comb begin
    cyq = QUAT_ONE - (34'(qc) <<< 1);
    syq = 34'(qs) <<< 1;
    case (job)
      JOB_DIST: begin
        sx = VW'(dx) <<< GUARD;
        sy = VW'(dy) <<< GUARD;
      end
      JOB_YAW: begin
        sx = VW'(cyq) <<< GUARD;
        sy = VW'(syq) <<< GUARD;
      end
      JOB_SPEED: begin
        sx = VW'(cvx) <<< GUARD;
        sy = VW'(cvy) <<< GUARD;
      end
      default: begin
        sx = '0;
        sy = '0;
      end
    endcase
  end

  // cordic micro-rotation
  always_comb begin
    xs  = cx >>> it;
    ys  = cy >>> it;
    at  = AW'(atan_entry(5'(it)));
    dir = (job == JOB_ROT) ? !cz[AW-1] : (cy[VW-1] || cy == '0);
    if (dir) begin
      cx_n = cx - ys;
      cy_n = cy + xs;
      cz_n = cz - at;
    end else begin
      cx_n = cx + ys;
      cy_n = cy - xs;
      cz_n = cz + at;
    end
  end

  always_comb begin
    ux       = cx[VW-1] ? '0 : cx;
    mag_full = ({18'd0, pr[53:0]} << 24) + {18'd0, acc};
    mag      = mag_full[71:38];
    enter    = (r_en > r_ad) ? r_ad : r_en;
    exitd    = (r_ex < enter) ? {1'b0, enter} + TENTH : {1'b0, r_ex};
    if (!direct_mode && goal_dist < DW'(enter)) begin
      dm_n = 1'b1;
    end else if (direct_mode && goal_dist > DW'(exitd)) begin
      dm_n = 1'b0;
    end else begin
      dm_n = direct_mode;
    end
    tgt_raw = pr[49:8];
    rlen_s  = {{(VW-39){1'b0}}, pr[60:22]};
    pabs    = pr[PW-1] ? PW'(-pr) : PW'(pr);
    rs      = {rem, nlo[31]};
    rge     = rs >= {1'b0, spd};
    quo_s   = dneg ? -$signed(quo) : $signed(quo);
    case (k)
      3'd0:    cmd_k = cvx;
      3'd1:    cmd_k = cvy;
      default: cmd_k = cwz;
    endcase
  end

  // shared multiplier operands
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_POST: begin
        ma = MAW'(ux[23:0]);
        mb = MBW'(INV_GAIN);
      end
      S_MAG1: begin
        ma = MAW'(ux[47:24]);
        mb = MBW'(INV_GAIN);
      end
      S_QUAT: begin
        case (k)
          3'd0: begin
            ma = MAW'(qw);
            mb = MBW'(qz);
          end
          3'd1: begin
            ma = MAW'(qx);
            mb = MBW'(qy);
          end
          3'd2: begin
            ma = MAW'(qy);
            mb = MBW'(qy);
          end
          3'd3: begin
            ma = MAW'(qz);
            mb = MBW'(qz);
          end
          default: ;
        endcase
      end
      S_TGT0: begin
        ma = MAW'(goal_dist);
        mb = MBW'(r_gain);
      end
      S_FOLD: begin
        ma = MAW'(target);
        mb = MBW'(INV_GAIN);
      end
      S_PROD: begin
        ma = MAW'(cmd_k);
        mb = MBW'(r_av);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (step.valid) begin
          if (step.op == OP_PLAN) state_next = S_IDLE;
          else if (goal_known) state_next = S_VLOAD;
          else state_next = S_OUT;
        end
      end
      S_VLOAD: state_next = S_ITER;
      S_ITER:  state_next = (it == ITER_LAST) ? S_POST : S_ITER;
      S_POST: begin
        unique case (job)
          JOB_YAW: state_next = S_TGT0;
          JOB_ROT: state_next = S_OUT;
          default: state_next = S_MAG1;
        endcase
      end
      S_MAG1: state_next = S_MAG2;
      S_MAG2: state_next = (job == JOB_DIST) ? S_DECIDE : S_SPDCHK;
      S_DECIDE: begin
        if (dm_n) state_next = S_QUAT;
        else if (goal_dist < DW'(r_ad)) state_next = S_VLOAD;
        else state_next = S_OUT;
      end
      S_QUAT:   state_next = (k == 3'd4) ? S_VLOAD : S_QUAT;
      S_TGT0:   state_next = S_TGT1;
      S_TGT1:   state_next = (goal_dist > EPS_DIST) ? S_ANG : S_OUT;
      S_ANG:    state_next = S_WRAP;
      S_WRAP:   state_next = (k == 3'd1) ? S_FOLD : S_WRAP;
      S_FOLD:   state_next = S_RLOAD;
      S_RLOAD:  state_next = S_ITER;
      S_SPDCHK: state_next = (spd > DW'(r_av)) ? S_PROD : S_CLAMP;
      S_PROD:   state_next = S_DVLD;
      S_DVLD:   state_next = S_DIV;
      S_DIV:    state_next = (dcnt == 5'd31) ? S_DSTORE : S_DIV;
      S_DSTORE: state_next = (k == 3'd2) ? S_CLAMP : S_PROD;
      S_CLAMP:  state_next = S_OUT;
      S_OUT:    state_next = result.ready ? S_IDLE : S_OUT;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cfg.ready            = 1'b1;
    step.ready           = (state == S_IDLE);
    result.valid         = (state == S_OUT);
    result.out_vx        = ovx;
    result.out_vy        = ovy;
    result.out_wz        = owz;
    result.direct_active = direct_mode;
    result.zone          = zone;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      job         <= JOB_DIST;
      it          <= '0;
      k           <= '0;
      dcnt        <= '0;
      goal_known  <= 1'b0;
      direct_mode <= 1'b0;
      r_ad        <= 31'd98304;
      r_av        <= 31'd32768;
      r_en        <= 31'd32768;
      r_ex        <= 31'd36045;
      r_gain      <= 16'd256;
      r_m         <= 31'd22938;
      r_gx        <= '0;
      r_gy        <= '0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        unique case (reg_idx_t'(cfg.index))
          REG_APPROACH_DIST:  r_ad   <= cfg.data[30:0];
          REG_APPROACH_SPEED: r_av   <= cfg.data[30:0];
          REG_ENTER_DIST:     r_en   <= cfg.data[30:0];
          REG_EXIT_DIST:      r_ex   <= cfg.data[30:0];
          REG_DIRECT_GAIN:    r_gain <= cfg.data[15:0];
          REG_MAX_YAW_RATE:   r_m    <= cfg.data[30:0];
          REG_GOAL_X:         r_gx   <= $signed(cfg.data);
          REG_GOAL_Y:         r_gy   <= $signed(cfg.data);
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (step.valid) begin
            job <= JOB_DIST;
            if (step.op == OP_PLAN) begin
              goal_known  <= 1'b1;
              direct_mode <= 1'b0;
            end
          end
        end
        S_VLOAD: it <= '0;
        S_ITER:  it <= it + 1'b1;
        S_DECIDE: begin
          direct_mode <= dm_n;
          k           <= '0;
          job         <= JOB_SPEED;
        end
        S_QUAT: begin
          k <= k + 1'b1;
          if (k == 3'd4) job <= JOB_YAW;
        end
        S_TGT1: k <= '0;
        S_WRAP: k <= k + 1'b1;
        S_FOLD: job <= JOB_ROT;
        S_RLOAD: it <= '0;
        S_SPDCHK: k <= '0;
        S_DVLD: dcnt <= '0;
        S_DIV: dcnt <= dcnt + 1'b1;
        S_DSTORE: k <= k + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    pr <= PW'(ma) * PW'(mb);
    case (state)
      S_IDLE: begin
        if (step.valid) begin
          cvx  <= step.cmd_vx;
          cvy  <= step.cmd_vy;
          cwz  <= step.cmd_wz;
          ovx  <= step.cmd_vx;
          ovy  <= step.cmd_vy;
          owz  <= step.cmd_wz;
          qw   <= step.quat_w;
          qx   <= step.quat_x;
          qy   <= step.quat_y;
          qz   <= step.quat_z;
          dx   <= 33'(r_gx) - 33'(step.pose_x);
          dy   <= 33'(r_gy) - 33'(step.pose_y);
          zone <= ZONE_NO_GOAL;
        end
      end
      S_VLOAD: begin
        vzero <= (sx == '0) && (sy == '0);
        if (sx[VW-1]) begin
          cx <= -sx;
          cy <= -sy;
          cz <= sy[VW-1] ? -ANG_PI : ANG_PI;
        end else begin
          cx <= sx;
          cy <= sy;
          cz <= '0;
        end
      end
      S_ITER: begin
        cx <= cx_n;
        cy <= cy_n;
        cz <= cz_n;
      end
      S_POST: begin
        case (job)
          JOB_DIST: phi     <= vzero ? '0 : cz;
          JOB_YAW:  yaw_ang <= vzero ? '0 : cz;
          JOB_ROT: begin
            ovx <= sat32(cx >>> GUARD);
            ovy <= sat32(cy >>> GUARD);
            owz <= '0;
          end
          default: ;
        endcase
      end
      S_MAG1: acc <= pr[53:0];
      S_MAG2: begin
        if (job == JOB_DIST) goal_dist <= mag;
        else spd <= mag;
      end
      S_DECIDE: begin
        if (dm_n) zone <= ZONE_DIRECT;
        else if (goal_dist < DW'(r_ad)) zone <= ZONE_APPROACH;
        else zone <= ZONE_PASS;
      end
      S_QUAT: begin
        case (k)
          3'd1: qs <= 33'(pr);
          3'd2: qs <= qs + 33'(pr);
          3'd3: qc <= 33'(pr);
          3'd4: qc <= qc + 33'(pr);
          default: ;
        endcase
      end
      S_TGT1: begin
        target <= (tgt_raw > {11'd0, r_av}) ? r_av : tgt_raw[30:0];
        if (goal_dist <= EPS_DIST) begin
          ovx <= '0;
          ovy <= '0;
          owz <= '0;
        end
      end
      S_ANG: begin
        ang  <= phi - yaw_ang;
        rneg <= 1'b0;
      end
      S_WRAP: begin
        if (ang > ANG_PI) ang <= ang - ANG_TWO_PI;
        else if (ang < -ANG_PI) ang <= ang + ANG_TWO_PI;
      end
      S_FOLD: begin
        if (ang > ANG_HALF_PI) begin
          ang  <= ang - ANG_PI;
          rneg <= 1'b1;
        end else if (ang < -ANG_HALF_PI) begin
          ang  <= ang + ANG_PI;
          rneg <= 1'b1;
        end
      end
      S_RLOAD: begin
        cx <= rneg ? -rlen_s : rlen_s;
        cy <= '0;
        cz <= ang;
      end
      S_DVLD: begin
        rem  <= 34'(pabs[62:32]);
        nlo  <= pabs[31:0];
        dneg <= pr[PW-1];
        quo  <= '0;
      end
      S_DIV: begin
        rem <= rge ? 34'(rs - {1'b0, spd}) : rs[33:0];
        nlo <= nlo << 1;
        quo <= {quo[30:0], rge};
      end
      S_DSTORE: begin
        case (k)
          3'd0:    ovx <= quo_s;
          3'd1:    ovy <= quo_s;
          default: owz <= quo_s;
        endcase
      end
      S_CLAMP: begin
        if (owz > $signed({1'b0, r_m})) owz <= $signed({1'b0, r_m});
        else if (owz < -$signed({1'b0, r_m})) owz <= -$signed({1'b0, r_m});
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/gavs_checker.sv @@
// ----------------------------------------------------------------------------
// gavs_checker
// Port-level checks of the goal approach velocity shaper, bound to the top.
// ----------------------------------------------------------------------------
`include "goal_approach_velocity_shaper_macros.svh"

module gavs_checker (
  input logic               clk,
  input logic               rst,
  input logic               step_valid,
  input logic               step_ready,
  input logic               step_op,
  input logic               result_valid,
  input logic               result_ready,
  input logic signed [31:0] out_vx,
  input logic signed [31:0] out_vy,
  input logic signed [31:0] out_wz,
  input logic               direct_active,
  input logic [1:0]         zone
);
  import gavs_pkg::*;

  `GAVS_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(out_vx) && $stable(out_vy) && $stable(out_wz) && $stable(zone) && $stable(direct_active), "stalled result beat changed")
  `GAVS_ASSERT_NOW(a_busy_on_result, result_valid, !step_ready, "step taken while result pending")
  `GAVS_ASSERT_NEXT(a_busy_after_step, step_valid && step_ready && step_op == OP_STEP, !step_ready, "ready right after a step beat")
  `GAVS_ASSERT_NOW(a_direct_zone, result_valid && zone == ZONE_DIRECT, direct_active && out_wz == '0, "direct zone without direct mode or with yaw rate")

endmodule

bind goal_approach_velocity_shaper gavs_checker u_gavs_checker (
  .clk           (clk),
  .rst           (rst),
  .step_valid    (step.valid),
  .step_ready    (step.ready),
  .step_op       (step.op),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .out_vx        (result.out_vx),
  .out_vy        (result.out_vy),
  .out_wz        (result.out_wz),
  .direct_active (result.direct_active),
  .zone          (result.zone)
);

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the goal approach velocity shaper: directed table,
// then randomized register phases with plan/step beats, random stalls on both
// channels, and a bit-accurate prediction of every result beat.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gavs_pkg::*;

  typedef struct {
    logic        op;
    logic [31:0] px, py;
    logic [15:0] qw, qx, qy, qz;
    logic [31:0] vx, vy, wz;
    bit          typed;
    zone_t       zone;
  } step_row_t;

  typedef struct {
    logic [31:0] vx, vy, wz;
    logic        da;
    zone_t       zone;
  } shaped_t;

  localparam int NSTEPS = 16;
  localparam longint unsigned INV = 64'd652032875;
  localparam longint M1 = 65536;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gavs_cfg_if    cfg();
  gavs_step_if   step();
  gavs_result_if result();

  goal_approach_velocity_shaper i_dut (
    .clk(clk), .rst(rst), .cfg(cfg.sink), .step(step.sink), .result(result.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  longint atan_lut[NSTEPS] = '{843314857, 497837830, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768};

  longint unsigned reg_val[8];
  bit      mode_direct;
  bit      have_goal;
  shaped_t shaped_q[$];
  int      errors;
  bit      quiet;
  bit      hold_req;

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic logic [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFFFFFF;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic void vector_mag(input longint x, input longint y,
                                     output longint unsigned mag, output longint ang);
    longint z, xs, ys;
    longint unsigned ux, hi, lo;
    z = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      ang = 0;
      return;
    end
    if (x < 0) begin
      z = (y >= 0) ? longint'(ANG_PI) : -longint'(ANG_PI);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < NSTEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z += atan_lut[i];
      end else begin
        x = x - ys; y = y + xs; z -= atan_lut[i];
      end
    end
    ux = (x > 0) ? longint'(x) : 0;
    hi = ux >> 8;
    lo = ux & 64'hFF;
    mag = (hi * INV + ((lo * INV) >> 8)) >> 30;
    ang = z;
  endfunction

  function automatic void rotate_len(input longint unsigned len, input longint a,
                                     output longint xo, output longint yo);
    longint x, y, xs, ys, pi, tpi;
    pi = longint'(ANG_PI);
    tpi = longint'(ANG_TWO_PI);
    x = longint'((len * INV) >> 22);
    y = 0;
    if (a > pi) a -= tpi;
    if (a > pi) a -= tpi;
    if (a < -pi) a += tpi;
    if (a < -pi) a += tpi;
    if (a > longint'(ANG_HALF_PI)) begin
      a -= pi; x = -x;
    end else if (a < -longint'(ANG_HALF_PI)) begin
      a += pi; x = -x;
    end
    for (int i = 0; i < NSTEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (a >= 0) begin
        x = x - ys; y = y + xs; a -= atan_lut[i];
      end else begin
        x = x + ys; y = y - xs; a += atan_lut[i];
      end
    end
    xo = x >>> 8;
    yo = y >>> 8;
  endfunction

  function automatic bit shape_cmd(input step_row_t s, output shaped_t r);
    longint cvx, cvy, cwz, ovx, ovy, owz, dx, dy, phi, yaw, qw, qx, qy, qz, sy, cy, m, ua;
    longint unsigned ad, av, enter, exitd, goal_dist, um, target, speed, eps;
    zone_t z;
    if (s.op == OP_PLAN) begin
      have_goal = 1;
      mode_direct = 0;
      return 0;
    end
    cvx = longint'($signed(s.vx));
    cvy = longint'($signed(s.vy));
    cwz = longint'($signed(s.wz));
    ovx = cvx; ovy = cvy; owz = cwz;
    z = ZONE_NO_GOAL;
    if (have_goal) begin
      ad = reg_val[REG_APPROACH_DIST];
      av = reg_val[REG_APPROACH_SPEED];
      enter = (reg_val[REG_ENTER_DIST] > ad) ? ad : reg_val[REG_ENTER_DIST];
      exitd = (reg_val[REG_EXIT_DIST] < enter) ? enter + TENTH : reg_val[REG_EXIT_DIST];
      eps = EPS_DIST;
      dx = longint'($signed(reg_val[REG_GOAL_X][31:0])) - longint'($signed(s.px));
      dy = longint'($signed(reg_val[REG_GOAL_Y][31:0])) - longint'($signed(s.py));
      vector_mag(dx * 256, dy * 256, goal_dist, phi);
      if (!mode_direct && goal_dist < enter) mode_direct = 1;
      else if (mode_direct && goal_dist > exitd) mode_direct = 0;
      if (mode_direct) begin
        qw = longint'($signed(s.qw)); qx = longint'($signed(s.qx));
        qy = longint'($signed(s.qy)); qz = longint'($signed(s.qz));
        sy = 2 * (qw * qz + qx * qy);
        cy = (longint'(1) << 28) - 2 * (qy * qy + qz * qz);
        vector_mag(cy * 256, sy * 256, um, yaw);
        target = (goal_dist * reg_val[REG_DIRECT_GAIN]) >> 8;
        if (target > av) target = av;
        if (goal_dist > eps) rotate_len(target, phi - yaw, ovx, ovy);
        else begin
          ovx = 0; ovy = 0;
        end
        owz = 0;
        z = ZONE_DIRECT;
      end else if (goal_dist < ad) begin
        m = longint'(reg_val[REG_MAX_YAW_RATE]);
        vector_mag(cvx * 256, cvy * 256, speed, ua);
        if (speed > av) begin
          ovx = cvx * longint'(av) / longint'(speed);
          ovy = cvy * longint'(av) / longint'(speed);
          owz = cwz * longint'(av) / longint'(speed);
        end
        if (owz > m) owz = m;
        if (owz < -m) owz = -m;
        z = ZONE_APPROACH;
      end else begin
        z = ZONE_PASS;
      end
    end
    r.vx = clip32(ovx);
    r.vy = clip32(ovy);
    r.wz = clip32(owz);
    r.da = mode_direct;
    r.zone = z;
    return 1;
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
    @(negedge clk);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = data;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      REG_DIRECT_GAIN:    reg_val[idx] = data & 32'hFFFF;
      REG_GOAL_X, REG_GOAL_Y: reg_val[idx] = data;
      default:            reg_val[idx] = data & 32'h7FFFFFFF;
    endcase
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    step.valid = 1'b0;
    wait (shaped_q.size() == 0);
    repeat (200) @(posedge clk);
  endtask

  task automatic send_step(input step_row_t s);
    shaped_t r;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      step.valid = 1'b0;
      repeat ($urandom_range(0, 9)) @(negedge clk);
    end
    @(negedge clk);
    step.valid  = 1'b1;
    step.op     = s.op;
    step.pose_x = s.px;  step.pose_y = s.py;
    step.quat_w = s.qw;  step.quat_x = s.qx;
    step.quat_y = s.qy;  step.quat_z = s.qz;
    step.cmd_vx = s.vx;  step.cmd_vy = s.vy;  step.cmd_wz = s.wz;
    do @(posedge clk); while (!step.ready);
    if (shape_cmd(s, r)) begin
      if (s.typed) begin
        r.vx = s.vx; r.vy = s.vy; r.wz = s.wz; r.da = 1'b0; r.zone = s.zone;
      end
      shaped_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    shaped_t e;
    if (!rst && result.valid && result.ready) begin
      if (shaped_q.size() == 0) report("result beat with nothing expected");
      else begin
        e = shaped_q.pop_front();
        if (result.out_vx !== e.vx)
          report($sformatf("out_vx %h exp %h", result.out_vx, e.vx));
        if (result.out_vy !== e.vy)
          report($sformatf("out_vy %h exp %h", result.out_vy, e.vy));
        if (result.out_wz !== e.wz)
          report($sformatf("out_wz %h exp %h", result.out_wz, e.wz));
        if (result.direct_active !== e.da)
          report($sformatf("direct_active %b exp %b", result.direct_active, e.da));
        if (result.zone !== e.zone)
          report($sformatf("zone %0d exp %0d", result.zone, e.zone));
      end
    end
  end

  initial begin
    int n;
    forever begin
      if (hold_req) begin
        result.ready = 1'b0;
        n = 0;
        while (n < 400) begin
          @(negedge clk);
          n++;
        end
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        result.ready = 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end else begin
        result.ready = 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  initial begin
    #20ms;
    $display("tb_top failed");
    $finish;
  end

  step_row_t dir_rows[18] = '{
    '{OP_STEP, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h4000, 16'h4000, 16'h4000, 16'h4000,
      32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1, ZONE_NO_GOAL},
    '{OP_STEP, 32'h80000000, 32'h80000000, 16'hC000, 16'hC000, 16'hC000, 16'hC000,
      32'h80000000, 32'h80000000, 32'h80000000, 1'b1, ZONE_NO_GOAL},
    '{OP_PLAN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0, ZONE_PASS},
    '{OP_STEP, 32'd655360, 0, 16'h4000, 0, 0, 0, 32'd65536, 0, 32'd13107, 1'b0, ZONE_PASS},
    '{OP_STEP, 32'd65536, 0, 16'h4000, 0, 0, 0, 32'd65536, 32'd65536, 32'd65536, 1'b0,
      ZONE_PASS},
    '{OP_STEP, 32'd65536, 0, 16'h4000, 0, 0, 0, 32'd6554, 0, -32'sd65536, 1'b0, ZONE_PASS},
    '{OP_STEP, 32'd19661, 32'd13107, 16'd11585, 0, 0, 16'd11585, 32'd65536, 0, 32'd65536,
      1'b0, ZONE_PASS},
    '{OP_STEP, 32'd34079, 0, 16'h4000, 0, 0, 0, 32'd100, 32'd100, 32'd100, 1'b0, ZONE_PASS},
    '{OP_STEP, 32'd39322, 0, 16'h4000, 0, 0, 0, 32'd100, 32'd100, 32'd100, 1'b0, ZONE_PASS},
    '{OP_STEP, 32'd34079, 0, 16'h4000, 0, 0, 0, 32'd100, 32'd100, 32'd100, 1'b0, ZONE_PASS},
    '{OP_STEP, 0, 0, 16'h4000, 0, 0, 0, 32'd500, 32'd500, 32'd500, 1'b0, ZONE_PASS},
    '{OP_STEP, 32'd6554, 32'd6554, 0, 0, 0, 0, 32'd500, 32'd500, 32'd500, 1'b0, ZONE_PASS},
    '{OP_STEP, 32'h80000000, 32'h80000000, 16'h4000, 0, 0, 0, 32'd7, 32'd8, 32'd9, 1'b0,
      ZONE_PASS},
    '{OP_STEP, 32'd13107, 0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'd1, 32'd1, 32'd1,
      1'b0, ZONE_PASS},
    '{OP_PLAN, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
      32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, ZONE_PASS},
    '{OP_STEP, 32'd13107, 0, 0, 0, 0, 16'h4000, 32'd1, 32'd1, 32'd1, 1'b0, ZONE_PASS},
    '{OP_STEP, 32'd65536, 0, 16'h4000, 0, 0, 0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
      1'b0, ZONE_PASS},
    '{OP_STEP, 32'd65536, 0, 16'h4000, 0, 0, 0, 0, 0, 0, 1'b0, ZONE_PASS}
  };

  initial begin
    step_row_t s;
    longint unsigned ad, r;
    logic [31:0] gx, gy;
    reg_val = '{98304, 32768, 32768, 36045, 256, 22938, 0, 0};
    mode_direct = 0;
    have_goal = 0;
    errors = 0;
    quiet = 0;
    hold_req = 0;
    cfg.valid = 1'b0; cfg.index = REG_APPROACH_DIST; cfg.data = '0;
    step.valid = 1'b0; step.op = OP_PLAN;
    step.pose_x = '0; step.pose_y = '0;
    step.quat_w = '0; step.quat_x = '0; step.quat_y = '0; step.quat_z = '0;
    step.cmd_vx = '0; step.cmd_vy = '0; step.cmd_wz = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) send_step(dir_rows[i]);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      if (ph == 0) begin
        for (int k = 0; k < 8; k++) write_reg(reg_idx_t'(k), 32'h0);
      end else if (ph == 1) begin
        for (int k = 0; k < 6; k++) write_reg(reg_idx_t'(k), 32'hFFFFFFFF);
        write_reg(REG_GOAL_X, 32'h7FFFFFFF);
        write_reg(REG_GOAL_Y, 32'h80000000);
      end else begin
        ad = $urandom_range(32768, 4 * M1);
        write_reg(REG_APPROACH_DIST, ad);
        write_reg(REG_APPROACH_SPEED, $urandom_range(0, 3 * M1));
        write_reg(REG_ENTER_DIST, $urandom_range(0, ad + M1));
        write_reg(REG_EXIT_DIST, $urandom_range(0, ad + M1));
        write_reg(REG_DIRECT_GAIN, $urandom_range(0, 1024));
        write_reg(REG_MAX_YAW_RATE, $urandom_range(0, 2 * M1));
        write_reg(REG_GOAL_X, $urandom_range(0, 200 * M1) - 100 * M1);
        write_reg(REG_GOAL_Y, $urandom_range(0, 200 * M1) - 100 * M1);
      end
      if (ph == 2) hold_req = 1;
      quiet = (ph == 5);
      ad = reg_val[REG_APPROACH_DIST];
      if (ad > 8 * M1) ad = 8 * M1;
      gx = reg_val[REG_GOAL_X][31:0];
      gy = reg_val[REG_GOAL_Y][31:0];
      for (int n = 0; n < 225; n++) begin
        s.typed = 0;
        s.zone  = ZONE_PASS;
        s.op    = (n == 0 || $urandom_range(0, 19) == 0) ? OP_PLAN : OP_STEP;
        if ($urandom_range(0, 9) == 0) begin
          s.px = $urandom; s.py = $urandom;
          s.qw = $urandom; s.qx = $urandom; s.qy = $urandom; s.qz = $urandom;
          s.vx = $urandom; s.vy = $urandom; s.wz = $urandom;
        end else begin
          r = $urandom_range(0, 2 * ad + M1);
          s.px = gx - (32'($urandom_range(0, 2 * r)) - 32'(r));
          s.py = gy - (32'($urandom_range(0, 2 * r)) - 32'(r));
          s.qw = $urandom_range(0, 32768) - 16384;
          s.qx = $urandom_range(0, 8192) - 4096;
          s.qy = $urandom_range(0, 8192) - 4096;
          s.qz = $urandom_range(0, 32768) - 16384;
          s.vx = $urandom_range(0, 4 * M1) - 2 * M1;
          s.vy = $urandom_range(0, 4 * M1) - 2 * M1;
          s.wz = $urandom_range(0, 4 * M1) - 2 * M1;
        end
        send_step(s);
      end
    end

    @(negedge clk);
    step.valid = 1'b0;
    wait (shaped_q.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule
